[sv/csc_pkg.sv]
package csc_pkg;

  localparam int OFFS_W   = 32;
  localparam int LEN_W    = 16;
  localparam int SCORE_W  = 22;
  localparam int PRED_W   = 7;
  localparam int CIDX_W   = 6;
  localparam int INDEL_W  = 33;
  localparam int DIFF_W   = 35;

  typedef struct packed {
    logic [OFFS_W-1:0]  target;
    logic [OFFS_W-1:0]  query;
    logic [LEN_W-1:0]   len;
    logic [SCORE_W-1:0] score;
    logic [PRED_W-1:0]  pred;
  } seed_rec_t;

endpackage

[sv/colinear_seed_chainer_core.sv]
// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+-------------------------
// input    | in_target_offset, in_query_offset, in_seed_length, | start & !busy
//          | in_last_seed                                       |
// result   | out_chain_index, out_target, out_query, out_length,| out_valid, one cycle each
//          | out_total_length, out_max_indel, out_last_result   |
//
// A seed at store position i holds busy high for a comparator pass over the earlier
// seeds at one store read a cycle, a drain of the last compare, then the write; the
// single read port of the seed store sets this. A seed with in_last_seed adds the chain
// start, a read and a wait per chain seed for the backtrack (each predecessor read depends
// on the last) and the S_E_RV to S_E_OUT states per result; busy drops with the last one.
// Reset clears the sequencer and set counters; stores keep no reset value; no result stalls.
module colinear_seed_chainer_core
  import csc_pkg::*;
#(
  parameter int MAX_SEEDS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OFFS_W-1:0]   in_target_offset,
  input  logic [OFFS_W-1:0]   in_query_offset,
  input  logic [LEN_W-1:0]    in_seed_length,
  input  logic                in_last_seed,
  output logic                out_valid,
  output logic [CIDX_W-1:0]   out_chain_index,
  output logic [OFFS_W-1:0]   out_target,
  output logic [OFFS_W-1:0]   out_query,
  output logic [LEN_W-1:0]    out_length,
  output logic [SCORE_W-1:0]  out_total_length,
  output logic [INDEL_W-1:0]  out_max_indel,
  output logic                out_last_result
);

  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam logic [CNT_W-1:0] FULL    = CNT_W'(MAX_SEEDS);
  localparam logic [CNT_W-1:0] NO_PRED = CNT_W'(MAX_SEEDS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_CHAIN = 4'd3;
  localparam logic [3:0] S_BT_RD = 4'd4;
  localparam logic [3:0] S_BT_WT = 4'd5;
  localparam logic [3:0] S_E_RV  = 4'd6;
  localparam logic [3:0] S_E_MR  = 4'd7;
  localparam logic [3:0] S_E_IND = 4'd8;
  localparam logic [3:0] S_E_OUT = 4'd9;

  seed_rec_t seed_mem [MAX_SEEDS];
  logic [IDX_W-1:0] rev_mem [MAX_SEEDS];

  logic [3:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [SCORE_W-1:0]  best_score_r, best_score_nxt;
  logic [CNT_W-1:0]    j_r, j_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic [SCORE_W-1:0]  pscore_r, pscore_nxt;
  logic [CNT_W-1:0]    pred_r, pred_nxt;
  logic [CNT_W-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [OFFS_W-1:0]   seed_t_r, seed_q_r;
  logic [LEN_W-1:0]    seed_len_r;
  logic                seed_last_r;
  logic [IDX_W-1:0]    rev_q_r;
  logic signed [DIFF_W-1:0] ind_r, cum_r, cum_nxt;
  logic [OFFS_W-1:0]   prev_t_r, prev_q_r;
  logic [SCORE_W-1:0]  total_r, total_nxt;
  logic [INDEL_W-1:0]  maxabs_r, maxabs_nxt;

  logic [CIDX_W-1:0]   o_idx_r;
  logic [OFFS_W-1:0]   o_t_r, o_q_r;
  logic [LEN_W-1:0]    o_len_r;
  logic [SCORE_W-1:0]  o_total_r;
  logic [INDEL_W-1:0]  o_indel_r, o_indel_nxt;
  logic                o_last_r, o_last_nxt;

  seed_rec_t        rd_data_r;
  seed_rec_t        wr_rec;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] rev_raddr;
  logic             accept;
  logic             hit;
  logic [OFFS_W:0]  tend, qend;
  logic [SCORE_W-1:0] new_score;
  logic signed [DIFF_W-1:0] dq, dt, ind_nxt;
  logic [DIFF_W-1:0] ind_abs, cum_abs;
  logic             bt_take;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // shared comparator: candidate ends at or before the new seed and scores higher
  assign tend = {1'b0, rd_data_r.target} + (OFFS_W+1)'(rd_data_r.len);
  assign qend = {1'b0, rd_data_r.query}  + (OFFS_W+1)'(rd_data_r.len);
  assign hit  = cmp_vld_r && ({1'b0, seed_t_r} >= tend) && ({1'b0, seed_q_r} >= qend)
                && (rd_data_r.score > pscore_r);

  assign new_score = pscore_r + SCORE_W'(seed_len_r);

  assign wr_rec.target = seed_t_r;
  assign wr_rec.query  = seed_q_r;
  assign wr_rec.len    = seed_len_r;
  assign wr_rec.score  = new_score;
  assign wr_rec.pred   = PRED_W'(pred_r);

  assign bt_take   = (state_r == S_BT_RD) && (n_r < FULL) && (cur_r < count_r);
  assign rev_raddr = IDX_W'(n_r - k_r - CNT_W'(1));

  assign dq      = DIFF_W'({3'b000, rd_data_r.query})  - DIFF_W'({3'b000, prev_q_r});
  assign dt      = DIFF_W'({3'b000, rd_data_r.target}) - DIFF_W'({3'b000, prev_t_r});
  assign ind_nxt = dq - dt;
  assign ind_abs = ind_r[DIFF_W-1] ? DIFF_W'(-ind_r) : DIFF_W'(ind_r);
  assign cum_abs = cum_nxt[DIFF_W-1] ? DIFF_W'(-cum_nxt) : DIFF_W'(cum_nxt);

  always_comb begin
    case (state_r)
      S_SCAN:  rd_addr = j_r[IDX_W-1:0];
      S_BT_RD: rd_addr = cur_r[IDX_W-1:0];
      S_E_MR:  rd_addr = rev_q_r;
      default: rd_addr = rev_q_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    best_idx_nxt   = best_idx_r;
    best_score_nxt = best_score_r;
    j_nxt          = j_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    pscore_nxt     = pscore_r;
    pred_nxt       = pred_r;
    cur_nxt        = cur_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    out_valid_nxt  = 1'b0;
    total_nxt      = total_r;
    maxabs_nxt     = maxabs_r;
    cum_nxt        = cum_r;
    o_indel_nxt    = '0;
    o_last_nxt     = 1'b0;

    if (hit) begin
      pscore_nxt = rd_data_r.score;
      pred_nxt   = CNT_W'(cmp_idx_r);
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          j_nxt      = '0;
          pscore_nxt = '0;
          pred_nxt   = NO_PRED;
          if (count_r < FULL) begin
            state_nxt = S_SCAN;
          end else if (in_last_seed) begin
            state_nxt = S_CHAIN;
          end
        end
      end
      S_SCAN: begin
        if (j_r < count_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = j_r[IDX_W-1:0];
          j_nxt       = j_r + CNT_W'(1);
        end else if (!cmp_vld_r) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        count_nxt = count_r + CNT_W'(1);
        if (new_score > best_score_r) begin
          best_score_nxt = new_score;
          best_idx_nxt   = count_r[IDX_W-1:0];
        end
        state_nxt = seed_last_r ? S_CHAIN : S_IDLE;
      end
      S_CHAIN: begin
        cur_nxt   = CNT_W'(best_idx_r);
        n_nxt     = '0;
        state_nxt = S_BT_RD;
      end
      S_BT_RD: begin
        if (bt_take) begin
          n_nxt     = n_r + CNT_W'(1);
          state_nxt = S_BT_WT;
        end else begin
          k_nxt      = '0;
          total_nxt  = '0;
          maxabs_nxt = '0;
          cum_nxt    = '0;
          state_nxt  = S_E_RV;
        end
      end
      S_BT_WT: begin
        cur_nxt   = CNT_W'(rd_data_r.pred);
        state_nxt = S_BT_RD;
      end
      S_E_RV:  state_nxt = S_E_MR;
      S_E_MR:  state_nxt = S_E_IND;
      S_E_IND: state_nxt = S_E_OUT;
      S_E_OUT: begin
        out_valid_nxt = 1'b1;
        total_nxt     = total_r + SCORE_W'(rd_data_r.len);
        if (k_r != '0) begin
          if (INDEL_W'(ind_abs) > maxabs_r) begin
            maxabs_nxt = INDEL_W'(ind_abs);
          end
          cum_nxt = cum_r + ind_r;
        end
        if (k_r == n_r - CNT_W'(1)) begin
          o_last_nxt  = 1'b1;
          o_indel_nxt = (maxabs_nxt > INDEL_W'(cum_abs)) ? maxabs_nxt : INDEL_W'(cum_abs);
          // chain done: start a fresh set
          count_nxt      = '0;
          best_idx_nxt   = '0;
          best_score_nxt = '0;
          state_nxt      = S_IDLE;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_E_RV;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      best_idx_r   <= '0;
      best_score_r <= '0;
      cmp_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      best_idx_r   <= best_idx_nxt;
      best_score_r <= best_score_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pscore_r  <= pscore_nxt;
    pred_r    <= pred_nxt;
    cur_r     <= cur_nxt;
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    total_r   <= total_nxt;
    maxabs_r  <= maxabs_nxt;
    cum_r     <= cum_nxt;
    if (accept) begin
      seed_t_r    <= in_target_offset;
      seed_q_r    <= in_query_offset;
      seed_len_r  <= in_seed_length;
      seed_last_r <= in_last_seed;
    end
    if (state_r == S_E_IND) begin
      ind_r <= ind_nxt;
    end
    if (state_r == S_E_OUT) begin
      prev_t_r  <= rd_data_r.target;
      prev_q_r  <= rd_data_r.query;
      o_idx_r   <= CIDX_W'(rev_q_r);
      o_t_r     <= rd_data_r.target;
      o_q_r     <= rd_data_r.query;
      o_len_r   <= rd_data_r.len;
      o_total_r <= o_last_nxt ? total_nxt : '0;
      o_indel_r <= o_indel_nxt;
      o_last_r  <= o_last_nxt;
    end
  end

  // seed store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      seed_mem[count_r[IDX_W-1:0]] <= wr_rec;
    end
    rd_data_r <= seed_mem[rd_addr];
  end

  // backtrack list, read back in reverse to emit in load order
  always_ff @(posedge clk) begin
    if (bt_take) begin
      rev_mem[n_r[IDX_W-1:0]] <= cur_r[IDX_W-1:0];
    end
    rev_q_r <= rev_mem[rev_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_chain_index  = o_idx_r;
  assign out_target       = o_t_r;
  assign out_query        = o_q_r;
  assign out_length       = o_len_r;
  assign out_total_length = o_total_r;
  assign out_max_indel    = o_indel_r;
  assign out_last_result  = o_last_r;

endmodule

[bench/tb_colinear_seed_chainer_core.sv]
`timescale 1ns / 1ps

module tb_colinear_seed_chainer_core
  import csc_pkg::*;
();

  localparam int MAX_SEEDS = 64;
  localparam int ITEM_TARGET = 460;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 600;
  localparam logic [PRED_W-1:0] NO_LINK = PRED_W'(MAX_SEEDS);

  typedef struct {
    logic [CIDX_W-1:0]  idx;
    logic [OFFS_W-1:0]  tgt;
    logic [OFFS_W-1:0]  qry;
    logic [LEN_W-1:0]   len;
    logic [SCORE_W-1:0] total;
    logic [INDEL_W-1:0] indel;
    logic               last;
  } chain_beat_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OFFS_W-1:0] in_target_offset = '0;
  logic [OFFS_W-1:0] in_query_offset = '0;
  logic [LEN_W-1:0] in_seed_length = '0;
  logic in_last_seed = 1'b0;
  logic out_valid;
  logic [CIDX_W-1:0] out_chain_index;
  logic [OFFS_W-1:0] out_target;
  logic [OFFS_W-1:0] out_query;
  logic [LEN_W-1:0] out_length;
  logic [SCORE_W-1:0] out_total_length;
  logic [INDEL_W-1:0] out_max_indel;
  logic out_last_result;

  // chaining state as the block should hold it
  logic [OFFS_W-1:0] tgt_mem [MAX_SEEDS];
  logic [OFFS_W-1:0] qry_mem [MAX_SEEDS];
  logic [LEN_W-1:0] len_mem [MAX_SEEDS];
  logic [SCORE_W-1:0] score_mem [MAX_SEEDS];
  logic [PRED_W-1:0] link_mem [MAX_SEEDS];
  int unsigned seeds_held = 0;
  int unsigned best_idx = 0;
  logic [SCORE_W-1:0] best_score = '0;

  chain_beat_t expected_chain [$];
  int unsigned mismatches = 0;
  int unsigned seeds_sent = 0;
  int unsigned idle_cycles = 0;

  colinear_seed_chainer_core #(
    .MAX_SEEDS(MAX_SEEDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_target_offset(in_target_offset),
    .in_query_offset(in_query_offset),
    .in_seed_length(in_seed_length),
    .in_last_seed(in_last_seed),
    .out_valid(out_valid),
    .out_chain_index(out_chain_index),
    .out_target(out_target),
    .out_query(out_query),
    .out_length(out_length),
    .out_total_length(out_total_length),
    .out_max_indel(out_max_indel),
    .out_last_result(out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void score_seed(logic [OFFS_W-1:0] t, logic [OFFS_W-1:0] q,
                                     logic [LEN_W-1:0] len);
    logic [OFFS_W:0] t_end;
    logic [OFFS_W:0] q_end;
    logic [SCORE_W-1:0] link_score;
    logic [PRED_W-1:0] link;
    logic [SCORE_W-1:0] score;
    link_score = '0;
    link = NO_LINK;
    // drop seeds that arrive once the set is full
    if (seeds_held >= MAX_SEEDS) return;
    for (int j = 0; j < seeds_held; j++) begin
      t_end = {1'b0, tgt_mem[j]} + (OFFS_W+1)'(len_mem[j]);
      q_end = {1'b0, qry_mem[j]} + (OFFS_W+1)'(len_mem[j]);
      if ({1'b0, t} >= t_end && {1'b0, q} >= q_end && score_mem[j] > link_score) begin
        link_score = score_mem[j];
        link = PRED_W'(j);
      end
    end
    score = link_score + SCORE_W'(len);
    tgt_mem[seeds_held] = t;
    qry_mem[seeds_held] = q;
    len_mem[seeds_held] = len;
    score_mem[seeds_held] = score;
    link_mem[seeds_held] = link;
    if (score > best_score) begin
      best_score = score;
      best_idx = seeds_held;
    end
    seeds_held++;
  endfunction

  function automatic void trace_chain();
    int unsigned order [MAX_SEEDS];
    int unsigned n;
    int unsigned cur;
    int unsigned idx;
    int unsigned prv;
    logic [SCORE_W-1:0] total;
    longint worst;
    longint cum;
    longint step_indel;
    chain_beat_t beat;
    n = 0;
    cur = best_idx;
    total = '0;
    worst = 0;
    cum = 0;
    if (seeds_held == 0) return;
    // walk back from the best node, then emit in load order
    while (n < MAX_SEEDS && cur < seeds_held) begin
      order[n] = cur;
      n++;
      cur = 32'(link_mem[cur]);
    end
    for (int k = 0; k < n; k++) begin
      idx = order[n-1-k];
      total += SCORE_W'(len_mem[idx]);
      if (k > 0) begin
        prv = order[n-k];
        step_indel = (longint'(qry_mem[idx]) - longint'(qry_mem[prv]))
                   - (longint'(tgt_mem[idx]) - longint'(tgt_mem[prv]));
        if (step_indel < 0) step_indel = -step_indel;
        if (step_indel > worst) worst = step_indel;
        cum += (longint'(qry_mem[idx]) - longint'(qry_mem[prv]))
             - (longint'(tgt_mem[idx]) - longint'(tgt_mem[prv]));
      end
      beat.idx = CIDX_W'(idx);
      beat.tgt = tgt_mem[idx];
      beat.qry = qry_mem[idx];
      beat.len = len_mem[idx];
      beat.total = '0;
      beat.indel = '0;
      beat.last = 1'b0;
      if (k == n - 1) begin
        if (cum < 0) cum = -cum;
        beat.total = total;
        beat.indel = INDEL_W'((worst > cum) ? worst : cum);
        beat.last = 1'b1;
      end
      expected_chain = {expected_chain, beat};
    end
  endfunction

  task automatic send_seed(logic [OFFS_W-1:0] t, logic [OFFS_W-1:0] q,
                           logic [LEN_W-1:0] len, logic last, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_target_offset <= t;
    in_query_offset <= q;
    in_seed_length <= len;
    in_last_seed <= last;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (seeds_held < MAX_SEEDS || last) seeds_sent++;
    score_seed(t, q, len);
    if (last) begin
      trace_chain();
      seeds_held = 0;
      best_idx = 0;
      best_score = '0;
    end
  endtask

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s expected %0h actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    chain_beat_t want;
    if (rst_n && out_valid) begin
      if (expected_chain.size() == 0) begin
        $display("%0t unexpected result expected none actual index %0d", $time,
                 out_chain_index);
        mismatches++;
      end else begin
        want = expected_chain.pop_front();
        check_field("chain_index", 64'(want.idx), 64'(out_chain_index));
        check_field("target", 64'(want.tgt), 64'(out_target));
        check_field("query", 64'(want.qry), 64'(out_query));
        check_field("length", 64'(want.len), 64'(out_length));
        check_field("total_length", 64'(want.total), 64'(out_total_length));
        check_field("max_indel", 64'(want.indel), 64'(out_max_indel));
        check_field("last_result", 64'(want.last), 64'(out_last_result));
      end
    end
  end

  // end the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic test_single_seed();
    send_seed(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, draw_gap(0));
  endtask

  task automatic test_colinear_chain();
    // touching ends qualify; the stray seed overlaps on target
    send_seed(32'd100, 32'd200, 16'd10, 1'b0, draw_gap(0));
    send_seed(32'd110, 32'd210, 16'd5, 1'b0, draw_gap(0));
    send_seed(32'd50, 32'd500, 16'd3, 1'b0, draw_gap(0));
    send_seed(32'd115, 32'd215, 16'd20, 1'b0, draw_gap(0));
    send_seed(32'd200, 32'd100, 16'd7, 1'b1, draw_gap(0));
  endtask

  task automatic test_ties_and_zero_length();
    // two equal candidates: the lower index must win; zero length keeps best node
    send_seed(32'd0, 32'd0, 16'd8, 1'b0, draw_gap(0));
    send_seed(32'd10, 32'd0, 16'd8, 1'b0, draw_gap(0));
    send_seed(32'd20, 32'd20, 16'd4, 1'b0, draw_gap(0));
    send_seed(32'd30, 32'd30, 16'd0, 1'b0, draw_gap(0));
    send_seed(32'd40, 32'd40, 16'd1, 1'b1, draw_gap(0));
  endtask

  task automatic test_no_positive_score();
    send_seed(32'd5, 32'd5, 16'd0, 1'b0, draw_gap(0));
    send_seed(32'd7, 32'd7, 16'd0, 1'b1, draw_gap(0));
  endtask

  task automatic test_offset_extremes();
    // seed end beyond 32 bits must not wrap into a predecessor
    send_seed(32'hFFFF_FFF0, 32'hFFFF_FFF0, 16'h0020, 1'b0, draw_gap(0));
    send_seed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 1'b1, draw_gap(0));
    // large negative indel
    send_seed(32'd0, 32'd0, 16'd1, 1'b0, draw_gap(0));
    send_seed(32'hFFFF_FFFE, 32'd1, 16'd1, 1'b1, draw_gap(0));
  endtask

  task automatic test_cumulative_indel();
    // same-sign indels: cumulative beats the largest single step
    send_seed(32'd0, 32'd0, 16'd1, 1'b0, draw_gap(0));
    send_seed(32'd10, 32'd100, 16'd1, 1'b0, draw_gap(0));
    send_seed(32'd20, 32'd200, 16'd1, 1'b1, draw_gap(0));
  endtask

  task automatic test_full_set();
    logic [OFFS_W-1:0] t;
    logic [OFFS_W-1:0] q;
    logic [LEN_W-1:0] len;
    bit burst;
    t = $urandom_range(0, 32'h00FF_FFFF);
    q = $urandom_range(0, 32'h00FF_FFFF);
    burst = 1'($urandom_range(0, 1));
    for (int k = 0; k < MAX_SEEDS; k++) begin
      len = LEN_W'($urandom_range(1, 64));
      send_seed(t, q, len, 1'b0, draw_gap(burst));
      t = t + OFFS_W'(len) + $urandom_range(0, 3);
      q = q + OFFS_W'(len) + $urandom_range(0, 3);
    end
    // both extra seeds land on a full set
    send_seed($urandom, $urandom, LEN_W'($urandom_range(1, 16'hFFFF)), 1'b0,
              draw_gap(burst));
    send_seed(t, q, LEN_W'($urandom_range(1, 16'hFFFF)), 1'b1, draw_gap(burst));
  endtask

  task automatic run_random_set(int unsigned size, bit colinear, bit burst);
    logic [OFFS_W-1:0] t;
    logic [OFFS_W-1:0] q;
    logic [OFFS_W-1:0] t_base;
    logic [OFFS_W-1:0] q_base;
    logic [LEN_W-1:0] len;
    int unsigned len_cap;
    int unsigned stride;
    len_cap = $urandom_range(0, 1) ? 64 : 65535;
    stride = $urandom_range(0, 1) ? 4 : 5000;
    t_base = $urandom;
    q_base = $urandom;
    t = t_base;
    q = q_base;
    len = '0;
    for (int k = 0; k < size; k++) begin
      if (k > 0) begin
        if (colinear && $urandom_range(0, 4) != 0) begin
          t = t + OFFS_W'(len) + $urandom_range(0, stride);
          q = q + OFFS_W'(len) + $urandom_range(0, stride);
        end else if ($urandom_range(0, 7) == 0) begin
          t = $urandom;
          q = $urandom;
        end else begin
          t = t_base + $urandom_range(0, 4 * len_cap + 2000);
          q = q_base + $urandom_range(0, 4 * len_cap + 2000);
        end
      end
      len = ($urandom_range(0, 39) == 0) ? '0 : LEN_W'($urandom_range(1, len_cap));
      send_seed(t, q, len, k == size - 1, draw_gap(burst));
    end
  endtask

  task automatic test_random_sets();
    int unsigned pick;
    int unsigned size;
    while (seeds_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) size = $urandom_range(1, 12);
      else if (pick < 97) size = $urandom_range(13, 40);
      else size = $urandom_range(60, 66);
      run_random_set(size, $urandom_range(0, 9) < 7, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_seed();
    test_colinear_chain();
    test_ties_and_zero_length();
    test_no_positive_score();
    test_offset_extremes();
    test_cumulative_indel();
    test_full_set();
    test_random_sets();
    start <= 1'b0;
    while (expected_chain.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chain.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[colinear_seed_chainer_core.f]
sv/csc_pkg.sv
sv/colinear_seed_chainer_core.sv
bench/tb_colinear_seed_chainer_core.sv
